// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/rris_pkg.sv -----
// Shared types and constants of the round-robin I/O scheduler.
package rris_pkg;

  localparam int unsigned MaxProcs = 16;
  localparam int unsigned SlotW    = $clog2(MaxProcs);
  localparam int unsigned CntW     = SlotW + 1;

  localparam logic [3:0] CMD_NONE   = 4'd0;
  localparam logic [3:0] CMD_ACCEPT = 4'd1;
  localparam logic [3:0] CMD_LOAD   = 4'd2;
  localparam logic [3:0] CMD_SCAN   = 4'd3;
  localparam logic [3:0] CMD_DISP   = 4'd4;
  localparam logic [3:0] CMD_RUN_RD = 4'd5;
  localparam logic [3:0] CMD_RUN_EX = 4'd6;
  localparam logic [3:0] CMD_IO_RD  = 4'd7;
  localparam logic [3:0] CMD_IO_EX  = 4'd8;
  localparam logic [3:0] CMD_LEAVE  = 4'd9;
  localparam logic [3:0] CMD_ST_RD  = 4'd10;
  localparam logic [3:0] CMD_ST_WR  = 4'd11;
  localparam logic [3:0] CMD_FIN    = 4'd12;

  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_FINISH = 2'd1;
  localparam logic [1:0] EV_IO     = 2'd2;
  localparam logic [1:0] EV_PREEMPT = 2'd3;

  typedef struct packed {
    logic [3:0] op;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
  } stat_t;

  typedef struct packed {
    logic [7:0]  label;
    logic [15:0] arrival;
    logic [15:0] remaining;
    logic [15:0] run_since_io;
    logic [15:0] io_interval;
    logic [15:0] io_duration;
    logic [15:0] io_left;
    logic        arrived;
  } slot_rec_t;

endpackage

// ----- hw/rtl/rris_ctrl.sv -----
// Controller state machine that sequences one request through the datapath.
module rris_ctrl import rris_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  logic  req_type_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  busy_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LOAD   = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_DISP   = 4'd3;
  localparam logic [3:0] S_RUN_RD = 4'd4;
  localparam logic [3:0] S_RUN_EX = 4'd5;
  localparam logic [3:0] S_IO_RD  = 4'd6;
  localparam logic [3:0] S_IO_EX  = 4'd7;
  localparam logic [3:0] S_LEAVE  = 4'd8;
  localparam logic [3:0] S_ST_RD  = 4'd9;
  localparam logic [3:0] S_ST_WR  = 4'd10;
  localparam logic [3:0] S_FIN    = 4'd11;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = CMD_NONE;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.op = CMD_ACCEPT;
          state_d  = req_type_i ? S_SCAN : S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.op = CMD_LOAD;
        state_d  = S_IDLE;
      end
      S_SCAN: begin
        cmd_o.op = CMD_SCAN;
        if (stat_i.scan_done) begin
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        cmd_o.op = CMD_DISP;
        state_d  = S_RUN_RD;
      end
      S_RUN_RD: begin
        cmd_o.op = CMD_RUN_RD;
        state_d  = S_RUN_EX;
      end
      S_RUN_EX: begin
        cmd_o.op = CMD_RUN_EX;
        state_d  = S_IO_RD;
      end
      S_IO_RD: begin
        cmd_o.op = CMD_IO_RD;
        state_d  = S_IO_EX;
      end
      S_IO_EX: begin
        cmd_o.op = CMD_IO_EX;
        state_d  = S_LEAVE;
      end
      S_LEAVE: begin
        cmd_o.op = CMD_LEAVE;
        state_d  = S_ST_RD;
      end
      S_ST_RD: begin
        cmd_o.op = CMD_ST_RD;
        state_d  = S_ST_WR;
      end
      S_ST_WR: begin
        cmd_o.op = CMD_ST_WR;
        state_d  = S_FIN;
      end
      S_FIN: begin
        cmd_o.op = CMD_FIN;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ----- hw/rtl/rris_datapath.sv -----
// Datapath: process table memory, queues, CPU and I/O device state, results.
`include "assert_macros.svh"
module rris_datapath import rris_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output stat_t       stat_o,
  input  logic        time_slice_we_i,
  input  logic [3:0]  time_slice_i,
  input  logic [7:0]  process_name_i,
  input  logic [15:0] arrival_time_i,
  input  logic [15:0] cpu_burst_i,
  input  logic [15:0] io_interval_i,
  input  logic [15:0] io_duration_i,
  output logic        done_o,
  output logic        load_rejected_o,
  output logic        running_valid_o,
  output logic [7:0]  running_name_o,
  output logic        io_valid_o,
  output logic [7:0]  io_name_o,
  output logic        finished_valid_o,
  output logic [7:0]  finished_name_o,
  output logic        all_done_o,
  output logic [15:0] time_now_o
);

  slot_rec_t mem [MaxProcs];
  slot_rec_t rd_q;
  logic [SlotW-1:0] raddr;
  logic             we;
  logic [SlotW-1:0] waddr;
  slot_rec_t        wdata;

  logic [7:0]  in_name_q;
  logic [15:0] in_arr_q, in_burst_q, in_int_q, in_dur_q;

  logic [3:0]  ts_q;
  logic [15:0] time_q, time_d;
  logic [CntW-1:0] loaded_q, loaded_d, fin_q, fin_d;
  logic [SlotW-1:0] run_slot_q, run_slot_d, io_slot_q, io_slot_d;
  logic run_ok_q, run_ok_d, io_ok_q, io_ok_d, start_pend_q, start_pend_d;
  logic [3:0] slice_q, slice_d;
  logic [CntW-1:0] scan_q, scan_d;
  logic chk_vld_q, chk_vld_d;
  logic [SlotW-1:0] chk_idx_q, chk_idx_d;
  logic ran_q, ran_d;
  logic [1:0] ev_q, ev_d;

  logic [SlotW-1:0] rq_mem [MaxProcs];
  logic [SlotW-1:0] iq_mem [MaxProcs];
  logic [SlotW-1:0] rq_head_q, iq_head_q;
  logic [CntW-1:0]  rq_cnt_q, iq_cnt_q;
  logic rq_push, rq_pop, iq_push, iq_pop;
  logic [SlotW-1:0] rq_val, iq_val;

  logic done_d, rej_d, rv_d, iov_d, fv_d, ad_d;
  logic [7:0] rn_d, ion_d, fn_d;
  logic [15:0] tn_d;

  logic [15:0] rem_n, rsi_n;
  logic [3:0]  slice_n, eff;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
    if (rq_push) begin
      rq_mem[rq_head_q + rq_cnt_q[SlotW-1:0]] <= rq_val;
    end
    if (iq_push) begin
      iq_mem[iq_head_q + iq_cnt_q[SlotW-1:0]] <= iq_val;
    end
    if (cmd_i.op == CMD_ACCEPT) begin
      in_name_q  <= process_name_i;
      in_arr_q   <= arrival_time_i;
      in_burst_q <= cpu_burst_i;
      in_int_q   <= io_interval_i;
      in_dur_q   <= io_duration_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q <= 4'd3;
      time_q <= '0;
      loaded_q <= '0;
      fin_q <= '0;
      run_slot_q <= '0;
      io_slot_q <= '0;
      run_ok_q <= 1'b0;
      io_ok_q <= 1'b0;
      start_pend_q <= 1'b0;
      slice_q <= '0;
      scan_q <= '0;
      chk_vld_q <= 1'b0;
      chk_idx_q <= '0;
      ran_q <= 1'b0;
      ev_q <= EV_NONE;
      rq_head_q <= '0;
      rq_cnt_q <= '0;
      iq_head_q <= '0;
      iq_cnt_q <= '0;
      done_o <= 1'b0;
      load_rejected_o <= 1'b0;
      running_valid_o <= 1'b0;
      running_name_o <= '0;
      io_valid_o <= 1'b0;
      io_name_o <= '0;
      finished_valid_o <= 1'b0;
      finished_name_o <= '0;
      all_done_o <= 1'b0;
      time_now_o <= '0;
    end else begin
      if (time_slice_we_i) begin
        ts_q <= time_slice_i;
      end
      time_q <= time_d;
      loaded_q <= loaded_d;
      fin_q <= fin_d;
      run_slot_q <= run_slot_d;
      io_slot_q <= io_slot_d;
      run_ok_q <= run_ok_d;
      io_ok_q <= io_ok_d;
      start_pend_q <= start_pend_d;
      slice_q <= slice_d;
      scan_q <= scan_d;
      chk_vld_q <= chk_vld_d;
      chk_idx_q <= chk_idx_d;
      ran_q <= ran_d;
      ev_q <= ev_d;
      rq_head_q <= rq_pop ? rq_head_q + 1'b1 : rq_head_q;
      rq_cnt_q <= rq_cnt_q + CntW'(rq_push) - CntW'(rq_pop);
      iq_head_q <= iq_pop ? iq_head_q + 1'b1 : iq_head_q;
      iq_cnt_q <= iq_cnt_q + CntW'(iq_push) - CntW'(iq_pop);
      done_o <= done_d;
      load_rejected_o <= rej_d;
      running_valid_o <= rv_d;
      running_name_o <= rn_d;
      io_valid_o <= iov_d;
      io_name_o <= ion_d;
      finished_valid_o <= fv_d;
      finished_name_o <= fn_d;
      all_done_o <= ad_d;
      time_now_o <= tn_d;
    end
  end

  assign rem_n   = (rd_q.remaining <= 16'd1) ? 16'd0 : rd_q.remaining - 16'd1;
  assign rsi_n   = rd_q.run_since_io + 16'd1;
  assign slice_n = (slice_q < 4'd15) ? slice_q + 4'd1 : slice_q;
  assign eff     = (ts_q == 4'd0) ? 4'd1 : ts_q;
  assign stat_o.scan_done = (scan_q >= loaded_q) && !chk_vld_q;

  always_comb begin
    raddr = scan_q[SlotW-1:0];
    we = 1'b0;
    waddr = chk_idx_q;
    wdata = rd_q;
    time_d = time_q;
    loaded_d = loaded_q;
    fin_d = fin_q;
    run_slot_d = run_slot_q;
    io_slot_d = io_slot_q;
    run_ok_d = run_ok_q;
    io_ok_d = io_ok_q;
    start_pend_d = start_pend_q;
    slice_d = slice_q;
    scan_d = scan_q;
    chk_vld_d = chk_vld_q;
    chk_idx_d = chk_idx_q;
    ran_d = ran_q;
    ev_d = ev_q;
    rq_push = 1'b0;
    rq_pop = 1'b0;
    rq_val = chk_idx_q;
    iq_push = 1'b0;
    iq_pop = 1'b0;
    iq_val = run_slot_q;
    done_d = 1'b0;
    rej_d = load_rejected_o;
    rv_d = running_valid_o;
    rn_d = running_name_o;
    iov_d = io_valid_o;
    ion_d = io_name_o;
    fv_d = finished_valid_o;
    fn_d = finished_name_o;
    ad_d = all_done_o;
    tn_d = time_now_o;
    case (cmd_i.op)
      CMD_ACCEPT: begin
        rej_d = 1'b0;
        rv_d = 1'b0;
        rn_d = '0;
        iov_d = 1'b0;
        ion_d = '0;
        fv_d = 1'b0;
        fn_d = '0;
        tn_d = time_q;
        scan_d = '0;
        chk_vld_d = 1'b0;
        ran_d = 1'b0;
        ev_d = EV_NONE;
      end
      CMD_LOAD: begin
        done_d = 1'b0;
        if (loaded_q < CntW'(MaxProcs)) begin
          we = 1'b1;
          waddr = loaded_q[SlotW-1:0];
          wdata.label = in_name_q;
          wdata.arrival = in_arr_q;
          wdata.remaining = in_burst_q;
          wdata.run_since_io = '0;
          wdata.io_interval = in_int_q;
          wdata.io_duration = in_dur_q;
          wdata.io_left = '0;
          wdata.arrived = 1'b0;
          loaded_d = loaded_q + 1'b1;
          ad_d = (fin_q == loaded_q + 1'b1);
        end else begin
          rej_d = 1'b1;
          ad_d = (fin_q == loaded_q);
        end
        done_d = 1'b1;
      end
      CMD_SCAN: begin
        if (chk_vld_q && !rd_q.arrived && (rd_q.arrival == time_q)) begin
          we = 1'b1;
          wdata.arrived = 1'b1;
          if (rq_cnt_q < CntW'(MaxProcs)) begin
            rq_push = 1'b1;
          end
        end
        if (scan_q < loaded_q) begin
          chk_vld_d = 1'b1;
          chk_idx_d = scan_q[SlotW-1:0];
          scan_d = scan_q + 1'b1;
        end else begin
          chk_vld_d = 1'b0;
        end
      end
      CMD_DISP: begin
        if (!run_ok_q && (rq_cnt_q != '0)) begin
          rq_pop = 1'b1;
          run_slot_d = rq_mem[rq_head_q];
          run_ok_d = 1'b1;
          slice_d = '0;
        end
      end
      CMD_RUN_RD: begin
        raddr = run_slot_q;
      end
      CMD_RUN_EX: begin
        if (run_ok_q) begin
          ran_d = 1'b1;
          rv_d = 1'b1;
          rn_d = rd_q.label;
          we = 1'b1;
          waddr = run_slot_q;
          wdata.remaining = rem_n;
          wdata.run_since_io = rsi_n;
          slice_d = slice_n;
          if (rem_n == 16'd0) begin
            ev_d = EV_FINISH;
          end else if ((rd_q.io_interval != 16'd0) && (rsi_n == rd_q.io_interval)) begin
            ev_d = EV_IO;
          end else if (slice_n >= eff) begin
            ev_d = EV_PREEMPT;
          end
        end
      end
      CMD_IO_RD: begin
        raddr = io_slot_q;
      end
      CMD_IO_EX: begin
        if (io_ok_q) begin
          iov_d = 1'b1;
          ion_d = rd_q.label;
          we = 1'b1;
          waddr = io_slot_q;
          if (rd_q.io_left <= 16'd1) begin
            wdata.io_left = '0;
            wdata.run_since_io = '0;
            if (ran_q) begin
              rq_val = io_slot_q;
              rq_push = (rq_cnt_q < CntW'(MaxProcs));
            end else begin
              run_slot_d = io_slot_q;
              run_ok_d = 1'b1;
              slice_d = '0;
            end
            io_ok_d = 1'b0;
            if (iq_cnt_q != '0) begin
              iq_pop = 1'b1;
              io_slot_d = iq_mem[iq_head_q];
              io_ok_d = 1'b1;
              start_pend_d = 1'b1;
            end
          end else begin
            wdata.io_left = rd_q.io_left - 16'd1;
          end
        end else if (iq_cnt_q != '0) begin
          iq_pop = 1'b1;
          io_slot_d = iq_mem[iq_head_q];
          io_ok_d = 1'b1;
          start_pend_d = 1'b1;
        end
      end
      CMD_LEAVE: begin
        case (ev_q)
          EV_FINISH: begin
            fin_d = fin_q + 1'b1;
            fv_d = 1'b1;
            fn_d = running_name_o;
            run_ok_d = 1'b0;
          end
          EV_IO: begin
            run_ok_d = 1'b0;
            if (io_ok_q) begin
              iq_push = (iq_cnt_q < CntW'(MaxProcs));
            end else begin
              io_slot_d = run_slot_q;
              io_ok_d = 1'b1;
              start_pend_d = 1'b1;
            end
          end
          EV_PREEMPT: begin
            run_ok_d = 1'b0;
            rq_val = run_slot_q;
            rq_push = (rq_cnt_q < CntW'(MaxProcs));
          end
          default: begin
            run_ok_d = run_ok_q;
          end
        endcase
      end
      CMD_ST_RD: begin
        raddr = io_slot_q;
      end
      CMD_ST_WR: begin
        if (start_pend_q) begin
          we = 1'b1;
          waddr = io_slot_q;
          wdata.io_left = rd_q.io_duration;
          start_pend_d = 1'b0;
        end
      end
      CMD_FIN: begin
        if (time_q != 16'hFFFF) begin
          time_d = time_q + 16'd1;
        end
        ad_d = (fin_q == loaded_q);
        done_d = 1'b1;
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  `ASSERT_ALWAYS(a_fin_le_loaded, fin_q <= loaded_q, "more finished than loaded")
  `ASSERT_ALWAYS(a_cpu_io_distinct, !(run_ok_q && io_ok_q) || (run_slot_q != io_slot_q),
    "same process on CPU and I/O device")
  `ASSERT_NEXT(a_done_pulse, done_o, !done_o, "result strobe longer than one cycle")

endmodule

// ----- hw/rtl/round_robin_io_scheduler.sv -----
// Top level of the round-robin CPU scheduler with one FIFO-served I/O device.
//
// A request is taken when start_i is high while busy_o is low. req_type_i
// selects a load (0), which stores a process in the next free table slot, or
// a tick (1), which advances the schedule by one time unit.
// Each request yields one result, shown on the result ports for exactly one
// cycle while done_o is high; the receiver cannot hold it off.
// A load stores its process in the load step, whose result is registered.
// A tick lasts longer the more processes are loaded, and is shortest while
// the table is empty:
// the arrival scan reads the process table through its single read port, one
// slot per cycle, and the CPU, I/O device and queue updates then use that
// port in fixed steps.
// busy_o drops in the strobe cycle, so the next request can be taken there.
// The time slice register is written by time_slice_we_i with time_slice_i
// and should only change while the block is idle.
// Reset clears the queues, the CPU and device, the counters and the time,
// and sets the time slice to 3.
module round_robin_io_scheduler import rris_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        time_slice_we_i,
  input  logic [3:0]  time_slice_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        req_type_i,
  input  logic [7:0]  process_name_i,
  input  logic [15:0] arrival_time_i,
  input  logic [15:0] cpu_burst_i,
  input  logic [15:0] io_interval_i,
  input  logic [15:0] io_duration_i,
  output logic        done_o,
  output logic        load_rejected_o,
  output logic        running_valid_o,
  output logic [7:0]  running_name_o,
  output logic        io_valid_o,
  output logic [7:0]  io_name_o,
  output logic        finished_valid_o,
  output logic [7:0]  finished_name_o,
  output logic        all_done_o,
  output logic [15:0] time_now_o
);

  cmd_t  cmd;
  stat_t stat;

  rris_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_type_i (req_type_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .busy_o     (busy_o)
  );

  rris_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .time_slice_we_i  (time_slice_we_i),
    .time_slice_i     (time_slice_i),
    .process_name_i   (process_name_i),
    .arrival_time_i   (arrival_time_i),
    .cpu_burst_i      (cpu_burst_i),
    .io_interval_i    (io_interval_i),
    .io_duration_i    (io_duration_i),
    .done_o           (done_o),
    .load_rejected_o  (load_rejected_o),
    .running_valid_o  (running_valid_o),
    .running_name_o   (running_name_o),
    .io_valid_o       (io_valid_o),
    .io_name_o        (io_name_o),
    .finished_valid_o (finished_valid_o),
    .finished_name_o  (finished_name_o),
    .all_done_o       (all_done_o),
    .time_now_o       (time_now_o)
  );

endmodule

// ----- bench/tb_round_robin_io_scheduler.sv -----
// Self-checking testbench for the round-robin I/O scheduler with a built-in scheduling predictor.
`timescale 1ns / 1ps

module tb_round_robin_io_scheduler;
  import rris_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam bit ReqLoad = 1'b0;
  localparam bit ReqTick = 1'b1;

  typedef struct {
    bit        kind;
    bit [7:0]  label;
    bit [15:0] arrival;
    bit [15:0] burst;
    bit [15:0] io_int;
    bit [15:0] io_dur;
  } sched_req_t;

  typedef struct packed {
    bit        rejected;
    bit        run_v;
    bit [7:0]  run_name;
    bit        io_v;
    bit [7:0]  io_nm;
    bit        fin_v;
    bit [7:0]  fin_name;
    bit        all_fin;
    bit [15:0] tick_no;
  } sched_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        time_slice_we_i = 1'b0;
  logic [3:0]  time_slice_i = 4'd0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic        req_type_i = 1'b0;
  logic [7:0]  process_name_i = 8'd0;
  logic [15:0] arrival_time_i = 16'd0;
  logic [15:0] cpu_burst_i = 16'd0;
  logic [15:0] io_interval_i = 16'd0;
  logic [15:0] io_duration_i = 16'd0;
  logic        done_o;
  logic        load_rejected_o;
  logic        running_valid_o;
  logic [7:0]  running_name_o;
  logic        io_valid_o;
  logic [7:0]  io_name_o;
  logic        finished_valid_o;
  logic [7:0]  finished_name_o;
  logic        all_done_o;
  logic [15:0] time_now_o;

  round_robin_io_scheduler dut (
    .clk_i, .rst_ni, .time_slice_we_i, .time_slice_i, .start_i, .busy_o,
    .req_type_i, .process_name_i, .arrival_time_i, .cpu_burst_i,
    .io_interval_i, .io_duration_i, .done_o, .load_rejected_o,
    .running_valid_o, .running_name_o, .io_valid_o, .io_name_o,
    .finished_valid_o, .finished_name_o, .all_done_o, .time_now_o
  );

  always #10 clk_i = ~clk_i;

  // Scheduler state as predicted.
  bit [7:0]  slot_lbl[MaxProcs];
  bit [15:0] slot_arr[MaxProcs];
  bit [15:0] slot_rem[MaxProcs];
  bit [15:0] slot_ran[MaxProcs];
  bit [15:0] slot_ioi[MaxProcs];
  bit [15:0] slot_iod[MaxProcs];
  bit [15:0] slot_iol[MaxProcs];
  bit        slot_came[MaxProcs];
  int unsigned ready_fifo[$];
  int unsigned io_fifo[$];
  int unsigned cpu_slot = 0;
  bit          cpu_busy = 1'b0;
  int unsigned dev_slot = 0;
  bit          dev_busy = 1'b0;
  int unsigned slice_used = 0;
  bit [15:0]   now_tick = 16'd0;
  int unsigned n_loaded = 0;
  int unsigned n_finished = 0;
  bit [3:0]    slice_reg = 4'd3;

  sched_req_t  pending_reqs[$];
  sched_res_t  expected_results[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned gap_left = 0;
  bit          gaps_on = 1'b1;
  int unsigned ticks_queued = 0;
  int unsigned loads_queued = 0;

  task automatic start_io(input int unsigned s);
    dev_slot = s;
    dev_busy = 1'b1;
    slot_iol[s] = slot_iod[s];
  endtask

  task automatic predict_request(input sched_req_t rq);
    sched_res_t r;
    int unsigned s;
    int unsigned d;
    int unsigned eff;
    bit ran;
    logic [1:0] ev;
    r = '{default: 0};
    r.tick_no = now_tick;
    if (rq.kind == ReqLoad) begin
      if (n_loaded < MaxProcs) begin
        slot_lbl[n_loaded] = rq.label;
        slot_arr[n_loaded] = rq.arrival;
        slot_rem[n_loaded] = rq.burst;
        slot_ioi[n_loaded] = rq.io_int;
        slot_iod[n_loaded] = rq.io_dur;
        slot_ran[n_loaded] = 16'd0;
        slot_iol[n_loaded] = 16'd0;
        slot_came[n_loaded] = 1'b0;
        n_loaded++;
      end else begin
        r.rejected = 1'b1;
      end
    end else begin
      for (int i = 0; i < n_loaded; i++) begin
        if (!slot_came[i] && slot_arr[i] == now_tick) begin
          slot_came[i] = 1'b1;
          if (ready_fifo.size() < MaxProcs) ready_fifo.push_back(i);
        end
      end
      if (!cpu_busy && ready_fifo.size() > 0) begin
        cpu_slot = ready_fifo.pop_front();
        cpu_busy = 1'b1;
        slice_used = 0;
      end
      ran = 1'b0;
      ev = EV_NONE;
      s = cpu_slot;
      if (cpu_busy) begin
        eff = (slice_reg == 0) ? 1 : slice_reg;
        ran = 1'b1;
        r.run_v = 1'b1;
        r.run_name = slot_lbl[s];
        slot_rem[s] = (slot_rem[s] <= 1) ? 16'd0 : slot_rem[s] - 16'd1;
        slot_ran[s] = slot_ran[s] + 16'd1;
        if (slice_used < 15) slice_used++;
        if (slot_rem[s] == 0) ev = EV_FINISH;
        else if (slot_ioi[s] != 0 && slot_ran[s] == slot_ioi[s]) ev = EV_IO;
        else if (slice_used >= eff) ev = EV_PREEMPT;
      end
      if (dev_busy) begin
        d = dev_slot;
        r.io_v = 1'b1;
        r.io_nm = slot_lbl[d];
        if (slot_iol[d] <= 1) begin
          slot_iol[d] = 16'd0;
          slot_ran[d] = 16'd0;
          if (ran) begin
            if (ready_fifo.size() < MaxProcs) ready_fifo.push_back(d);
          end else begin
            cpu_slot = d;
            cpu_busy = 1'b1;
            slice_used = 0;
          end
          dev_busy = 1'b0;
          if (io_fifo.size() > 0) start_io(io_fifo.pop_front());
        end else begin
          slot_iol[d] = slot_iol[d] - 16'd1;
        end
      end else if (io_fifo.size() > 0) begin
        start_io(io_fifo.pop_front());
      end
      case (ev)
        EV_FINISH: begin
          n_finished++;
          r.fin_v = 1'b1;
          r.fin_name = slot_lbl[s];
          cpu_busy = 1'b0;
        end
        EV_IO: begin
          cpu_busy = 1'b0;
          if (dev_busy) begin
            if (io_fifo.size() < MaxProcs) io_fifo.push_back(s);
          end else begin
            start_io(s);
          end
        end
        EV_PREEMPT: begin
          cpu_busy = 1'b0;
          if (ready_fifo.size() < MaxProcs) ready_fifo.push_back(s);
        end
        default: ;
      endcase
      if (now_tick != 16'hFFFF) now_tick = now_tick + 16'd1;
    end
    r.all_fin = (n_finished == n_loaded);
    expected_results.push_back(r);
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("round_robin_io_scheduler regression: fail");
      $finish;
    end
  end

  // Request driver.
  always @(posedge clk_i) begin
    sched_req_t nx;
    if (rst_ni) begin
      if (start_i && !busy_o) predict_request(pending_reqs[0]);
      if (start_i && !busy_o) void'(pending_reqs.pop_front());
      if (!start_i || !busy_o) begin
        if (start_i && gaps_on && $urandom_range(0, 5) == 0) begin
          gap_left <= $urandom_range(1, 8) - 1;
          start_i <= 1'b0;
        end else if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start_i <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          nx = pending_reqs[0];
          req_type_i <= nx.kind;
          process_name_i <= nx.label;
          arrival_time_i <= nx.arrival;
          cpu_burst_i <= nx.burst;
          io_interval_i <= nx.io_int;
          io_duration_i <= nx.io_dur;
          start_i <= 1'b1;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    sched_res_t act;
    sched_res_t exp_r;
    if (rst_ni && done_o) begin
      act = '{load_rejected_o, running_valid_o, running_name_o, io_valid_o, io_name_o,
              finished_valid_o, finished_name_o, all_done_o, time_now_o};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", act);
      end else begin
        exp_r = expected_results.pop_front();
        if (act != exp_r) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp_r, act);
        end
      end
    end
  end

  task automatic add_load(input bit [7:0] nm, input bit [15:0] arr, input bit [15:0] bu,
                          input bit [15:0] ioi, input bit [15:0] iod);
    pending_reqs.push_back('{ReqLoad, nm, arr, bu, ioi, iod});
    loads_queued++;
  endtask

  task automatic add_tick();
    pending_reqs.push_back('{ReqTick, 8'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom), 16'($urandom)});
    ticks_queued++;
  endtask

  task automatic add_random_load();
    if (loads_queued < MaxProcs)
      add_load(8'($urandom), 16'(ticks_queued + $urandom_range(0, 20)),
               16'($urandom_range(1, 40)), 16'($urandom_range(0, 6)),
               16'($urandom_range(0, 10)));
    else
      add_load(8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || start_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_slice(input bit [3:0] v);
    @(posedge clk_i);
    time_slice_we_i <= 1'b1;
    time_slice_i <= v;
    @(posedge clk_i);
    time_slice_we_i <= 1'b0;
    slice_reg = v;
  endtask

  initial begin
    bit [3:0] slices[4];
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_slice(4'd2);
    add_tick();
    add_load(8'hFF, 16'd1, 16'd0, 16'd0, 16'd0);
    add_load(8'h01, 16'd1, 16'd5, 16'd2, 16'd0);
    add_load(8'h02, 16'd2, 16'd7, 16'd3, 16'd4);
    add_load(8'h03, 16'd3, 16'd9, 16'd1, 16'd2);
    add_load(8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    repeat (12) add_tick();
    add_load(8'h55, 16'd4, 16'd3, 16'd0, 16'd0);
    repeat (4) add_tick();
    wait_idle();
    slices = '{4'd0, 4'd15, 4'd1, 4'($urandom_range(2, 14))};
    for (int ph = 0; ph < 4; ph++) begin
      write_slice(slices[ph]);
      if (ph == 3) gaps_on = 1'b0;
      repeat (3) add_random_load();
      for (int k = 0; k < 230; k++) begin
        if ($urandom_range(0, 9) == 0) add_random_load();
        else add_tick();
      end
      wait_idle();
    end
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("round_robin_io_scheduler regression: pass");
    else
      $display("round_robin_io_scheduler regression: fail");
    $finish;
  end

endmodule

// ----- round_robin_io_scheduler.f -----
+incdir+hw/rtl
hw/rtl/rris_pkg.sv
hw/rtl/rris_ctrl.sv
hw/rtl/rris_datapath.sv
hw/rtl/round_robin_io_scheduler.sv
bench/tb_round_robin_io_scheduler.sv
